// ===== src/ttcw_pkg.sv =====
`default_nettype none

package ttcw_pkg;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int TAB_WIDTH   = 4;
    localparam int CELL_TOTAL  = COLUMNS * ROWS;
    localparam int SCROLL_BASE = CELL_TOTAL - COLUMNS;

    localparam int CUR_W   = $clog2(CELL_TOTAL);
    localparam int LIN_NW  = CUR_W + 1;
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int TAB_SH  = $clog2(TAB_WIDTH);
    localparam int INDEX_W = 11;
    localparam int CELL_W  = 16;

    localparam logic [7:0] KEY_NEWLINE   = 8'd10;
    localparam logic [7:0] KEY_RETURN    = 8'd13;
    localparam logic [7:0] KEY_BACKSPACE = 8'd8;
    localparam logic [7:0] KEY_TAB       = 8'd9;
    localparam logic [7:0] BLANK_CHAR    = 8'h20;
    localparam logic [7:0] RESET_ATTR    = 8'h0F;

    typedef logic [CUR_W-1:0]  cell_addr_t;
    typedef logic [CELL_W-1:0] cell_t;

    localparam cell_addr_t LAST_CELL   = CUR_W'(CELL_TOTAL - 1);
    localparam cell_addr_t SCROLL_ADDR = CUR_W'(SCROLL_BASE);
    localparam cell_addr_t MOVE_LAST   = CUR_W'(SCROLL_BASE - 1);
    localparam cell_addr_t COLUMNS_A   = CUR_W'(COLUMNS);
    localparam cell_t      RESET_BLANK = {RESET_ATTR, BLANK_CHAR};

    typedef struct packed {
        logic       wr;
        logic       blank;
        cell_addr_t addr;
        logic       scroll;
        cell_addr_t cursor;
    } put_plan_t;

endpackage

`default_nettype wire

// ===== src/ttcw_screen_ram.sv =====
`default_nettype none

module ttcw_screen_ram (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire ttcw_pkg::cell_addr_t waddr,
    input  wire ttcw_pkg::cell_t      wdata,
    input  wire logic                 re,
    input  wire ttcw_pkg::cell_addr_t raddr,
    output ttcw_pkg::cell_t           rdata
);
    import ttcw_pkg::*;

    cell_t mem [CELL_TOTAL];
    cell_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/ttcw_cursor.sv =====
`default_nettype none

module ttcw_cursor (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 update,
    input  wire logic [7:0]           char_code,
    output ttcw_pkg::cell_addr_t      cursor,
    output ttcw_pkg::put_plan_t       plan
);
    import ttcw_pkg::*;

    cell_addr_t       lin_reg, lin_next;
    cell_addr_t       base_reg, base_next;
    logic [COL_W-1:0] col_reg, col_next;

    logic [LIN_NW-1:0] lin_w, base_w, lin_n, base_n;
    logic [COL_W:0]    delta, col_sum;
    logic [COL_W-1:0]  col_n;
    logic              is_tab, wrap, scroll;

    always_comb
    begin
        lin_w   = LIN_NW'(lin_reg);
        base_w  = LIN_NW'(base_reg);
        is_tab  = (char_code == KEY_TAB);
        delta   = is_tab ? ((COL_W + 1)'(TAB_WIDTH) - (COL_W + 1)'(lin_reg[TAB_SH-1:0]))
                         : (COL_W + 1)'(1);
        col_sum = {1'b0, col_reg} + delta;
        wrap    = (col_sum >= (COL_W + 1)'(COLUMNS));

        lin_n       = lin_w;
        base_n      = base_w;
        col_n       = col_reg;
        plan.wr     = 1'b0;
        plan.blank  = 1'b0;
        plan.addr   = lin_reg;

        case (char_code)
            KEY_NEWLINE:
            begin
                lin_n  = base_w + LIN_NW'(COLUMNS);
                base_n = base_w + LIN_NW'(COLUMNS);
                col_n  = '0;
            end
            KEY_RETURN:
            begin
                lin_n = base_w;
                col_n = '0;
            end
            KEY_BACKSPACE:
            begin
                if (lin_reg != '0)
                begin
                    lin_n      = lin_w - LIN_NW'(1);
                    plan.addr  = lin_reg - CUR_W'(1);
                    plan.wr    = 1'b1;
                    plan.blank = 1'b1;
                    if (col_reg == '0)
                    begin
                        col_n  = COL_W'(COLUMNS - 1);
                        base_n = base_w - LIN_NW'(COLUMNS);
                    end
                    else
                    begin
                        col_n = col_reg - COL_W'(1);
                    end
                end
            end
            default:
            begin
                lin_n   = lin_w + LIN_NW'(delta);
                plan.wr = !is_tab;
                if (wrap)
                begin
                    col_n  = COL_W'(col_sum - (COL_W + 1)'(COLUMNS));
                    base_n = base_w + LIN_NW'(COLUMNS);
                end
                else
                begin
                    col_n = col_sum[COL_W-1:0];
                end
            end
        endcase

        scroll = (lin_n >= LIN_NW'(CELL_TOTAL));
        if (scroll)
        begin
            lin_next  = SCROLL_ADDR;
            base_next = SCROLL_ADDR;
            col_next  = '0;
        end
        else
        begin
            lin_next  = lin_n[CUR_W-1:0];
            base_next = base_n[CUR_W-1:0];
            col_next  = col_n;
        end
        plan.scroll = scroll;
        plan.cursor = lin_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_reg  <= '0;
            base_reg <= '0;
            col_reg  <= '0;
        end
        else if (update)
        begin
            lin_reg  <= lin_next;
            base_reg <= base_next;
            col_reg  <= col_next;
        end
    end

    assign cursor = lin_reg;

endmodule

`default_nettype wire

// ===== src/text_terminal_cell_writer.sv =====
`default_nettype none

// Text terminal of 80x25 cells (attribute high byte, character low byte) with a linear
// cursor. Items are taken when start is high and busy is low; each item gives one result,
// shown for a single cycle with done high, and the receiver cannot stall it. A put that does
// not scroll gives its result in the next cycle, so puts can follow every cycle. A read's
// result passes through the registered screen memory read and then the result registers.
// A put that reaches the end of the screen scrolls: the single write port of the screen
// memory moves 1920 cells and blanks 80, one cell a cycle, before that result is given.
// After reset the block clears all 2000 cells of the screen store to 0x0F20 with busy
// high; text_attribute may be written meanwhile.

module text_terminal_cell_writer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           op,
    input  wire logic [7:0]                     char_code,
    input  wire logic [ttcw_pkg::INDEX_W-1:0]   cell_index,
    input  wire logic                           text_attribute_we,
    input  wire logic [7:0]                     text_attribute_wdata,
    output logic                                done,
    output logic [ttcw_pkg::CELL_W-1:0]         cell_value,
    output logic [ttcw_pkg::INDEX_W-1:0]        cursor_pos,
    output logic                                scrolled
);
    import ttcw_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CLEAR  = 3'd1;
    localparam logic [2:0] ST_RDWAIT = 3'd2;
    localparam logic [2:0] ST_MOVE   = 3'd3;
    localparam logic [2:0] ST_FILL   = 3'd4;

    logic [2:0] state_reg, state_next;
    cell_addr_t cnt_reg, cnt_next;
    logic       pend_reg, pend_next;
    cell_addr_t pend_addr_reg, pend_addr_next;
    logic       done_reg, done_next;
    logic [7:0] attr_reg;
    logic       in_range_reg, in_range_next;
    cell_t      cell_value_reg, cell_value_next;
    cell_addr_t cursor_pos_reg, cursor_pos_next;
    logic       scrolled_reg, scrolled_next;

    logic       accept, in_range, cursor_update;
    logic       ram_we, ram_re;
    cell_addr_t ram_waddr, ram_raddr, cur_lin;
    cell_t      ram_wdata, ram_rdata, blank_cell;
    put_plan_t  plan;

    ttcw_screen_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ttcw_cursor u_cursor (
        .clk       (clk),
        .rst_n     (rst_n),
        .update    (cursor_update),
        .char_code (char_code),
        .cursor    (cur_lin),
        .plan      (plan)
    );

    assign busy       = (state_reg != ST_IDLE);
    assign accept     = start && !busy;
    assign in_range   = (cell_index < INDEX_W'(CELL_TOTAL));
    assign blank_cell = {attr_reg, BLANK_CHAR};

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pend_next       = (state_reg == ST_MOVE);
        pend_addr_next  = cnt_reg;
        done_next       = 1'b0;
        in_range_next   = in_range_reg;
        cell_value_next = cell_value_reg;
        cursor_pos_next = cursor_pos_reg;
        scrolled_next   = scrolled_reg;
        cursor_update   = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = plan.addr;
        ram_wdata       = plan.blank ? blank_cell : {attr_reg, char_code};
        ram_re          = 1'b0;
        ram_raddr       = CUR_W'(cell_index);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op)
                    begin
                        ram_re        = in_range;
                        in_range_next = in_range;
                        state_next    = ST_RDWAIT;
                    end
                    else
                    begin
                        cursor_update = 1'b1;
                        ram_we        = plan.wr;
                        if (plan.scroll)
                        begin
                            cnt_next   = '0;
                            state_next = ST_MOVE;
                        end
                        else
                        begin
                            done_next       = 1'b1;
                            cell_value_next = '0;
                            cursor_pos_next = plan.cursor;
                            scrolled_next   = 1'b0;
                        end
                    end
                end
            end
            ST_RDWAIT:
            begin
                done_next       = 1'b1;
                cell_value_next = in_range_reg ? ram_rdata : '0;
                cursor_pos_next = cur_lin;
                scrolled_next   = 1'b0;
                state_next      = ST_IDLE;
            end
            ST_MOVE:
            begin
                ram_re    = 1'b1;
                ram_raddr = cnt_reg + COLUMNS_A;
                ram_we    = pend_reg;
                ram_waddr = pend_addr_reg;
                ram_wdata = ram_rdata;
                cnt_next  = cnt_reg + CUR_W'(1);
                if (cnt_reg == MOVE_LAST)
                begin
                    cnt_next   = SCROLL_ADDR;
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                ram_we = 1'b1;
                if (pend_reg)
                begin
                    ram_waddr = pend_addr_reg;
                    ram_wdata = ram_rdata;
                end
                else
                begin
                    ram_waddr = cnt_reg;
                    ram_wdata = blank_cell;
                    cnt_next  = cnt_reg + CUR_W'(1);
                    if (cnt_reg == LAST_CELL)
                    begin
                        cnt_next        = '0;
                        done_next       = 1'b1;
                        cell_value_next = '0;
                        cursor_pos_next = cur_lin;
                        scrolled_next   = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
            end
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = RESET_BLANK;
                cnt_next  = cnt_reg + CUR_W'(1);
                if (cnt_reg == LAST_CELL)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
            attr_reg  <= RESET_ATTR;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
            if (text_attribute_we)
            begin
                attr_reg <= text_attribute_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg  <= pend_addr_next;
        in_range_reg   <= in_range_next;
        cell_value_reg <= cell_value_next;
        cursor_pos_reg <= cursor_pos_next;
        scrolled_reg   <= scrolled_next;
    end

    assign done       = done_reg;
    assign cell_value = cell_value_reg;
    assign cursor_pos = INDEX_W'(cursor_pos_reg);
    assign scrolled   = scrolled_reg;

endmodule

`default_nettype wire

// ===== src/ttcw_checker.sv =====
`default_nettype none

module ttcw_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           start,
    input wire logic                           busy,
    input wire logic                           op,
    input wire logic                           done,
    input wire logic [ttcw_pkg::CELL_W-1:0]    cell_value,
    input wire logic [ttcw_pkg::INDEX_W-1:0]   cursor_pos,
    input wire logic                           scrolled
);
    import ttcw_pkg::*;

    // read transfer gives its result, never marked as a scroll
    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op) |-> ##2 (done && !scrolled))
        else $error("read result missing or marked scrolled");

    // put either finishes next cycle with zero data or starts a scroll
    a_put_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !op) |=> ((done && cell_value == '0 && !scrolled) || busy))
        else $error("put result missing");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (cursor_pos < INDEX_W'(CELL_TOTAL)))
        else $error("cursor beyond screen");

    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (done && scrolled) |-> (cursor_pos == INDEX_W'(SCROLL_BASE) && cell_value == '0))
        else $error("scroll left cursor off last row start");

endmodule

bind text_terminal_cell_writer ttcw_checker u_ttcw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .done       (done),
    .cell_value (cell_value),
    .cursor_pos (cursor_pos),
    .scrolled   (scrolled)
);

`default_nettype wire
